// ----- rtl/amwg_pkg.sv -----
package amwg_pkg;

  typedef longint unsigned u64_t;

  localparam int PHASE_BITS   = 32;
  localparam int SINE_ENTRIES = 1024;
  localparam int QTR_BITS     = $clog2(SINE_ENTRIES);
  localparam int TURN_BITS    = QTR_BITS + 2;
  localparam int ROM_AW       = $clog2(SINE_ENTRIES + 1);
  localparam int SINE_W       = 15;

  localparam int SAMPLE_W     = 19;
  localparam int INDEX_W      = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam u64_t PI_Q30     = 64'd3373259426;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CARRIER_STEP = 3'd0,
    REG_MOD_STEP     = 3'd1,
    REG_AMPLITUDE    = 3'd2,
    REG_MOD_DEPTH    = 3'd3,
    REG_NORM_GAIN    = 3'd4,
    REG_BURST_LENGTH = 3'd5
  } cfg_reg_e;

  // Restoring long division, used only while the sine table is built.
  function automatic u64_t div_small(input u64_t num, input u64_t den);
    u64_t quo;
    u64_t rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave entry u, built from a Q30 Taylor series at elaboration.
  function automatic logic [SINE_W-1:0] quarter_sine(input u64_t u);
    u64_t x;
    u64_t x2;
    u64_t term;
    u64_t pos;
    u64_t neg;
    u64_t s;
    u64_t e;
    x    = (PI_Q30 * u) >> (QTR_BITS + 1);
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = '0;
    for (int k = 1; k <= 8; k++) begin
      term = div_small((term * x2) >> 30, u64_t'((2 * k) * (2 * k + 1)));
      if (k % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    s = (pos > neg) ? pos - neg : u64_t'(0);
    e = (s * u64_t'(32767) + (u64_t'(1) << 29)) >> 30;
    if (e > u64_t'(32767)) begin
      e = u64_t'(32767);
    end
    return e[SINE_W-1:0];
  endfunction

endpackage

// ----- rtl/amwg_if.sv -----
interface amwg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface amwg_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [amwg_pkg::SAMPLE_W-1:0] sample;
  logic        [amwg_pkg::INDEX_W-1:0]  sample_index;
  logic                                 last;

  modport source (output valid, output sample, output sample_index, output last, input ready);
  modport sink   (input valid, input sample, input sample_index, input last, output ready);
endinterface

// ----- rtl/amwg_sine_rom.sv -----
module amwg_sine_rom (
  input  logic                          clk,
  input  logic [amwg_pkg::ROM_AW-1:0]   addr,
  output logic [amwg_pkg::SINE_W-1:0]   data
);

  logic [amwg_pkg::SINE_W-1:0] rom_mem [0:amwg_pkg::SINE_ENTRIES];
  logic [amwg_pkg::SINE_W-1:0] data_r;

  initial begin
    for (int u = 0; u <= amwg_pkg::SINE_ENTRIES; u++) begin
      rom_mem[u] = amwg_pkg::quarter_sine(amwg_pkg::u64_t'(u));
    end
  end

  always_ff @(posedge clk) begin
    data_r <= rom_mem[addr];
  end

  assign data = data_r;

endmodule

// ----- rtl/am_wave_generator_unit.sv -----
// Amplitude-modulated sine generator. Each beat on the input channel asks for one
// sample; its restart bit zeroes the burst index and both phase accumulators
// before that sample is made. Each result beat carries the sample, its index in
// the burst and a last flag; after a last sample the index and phases return to
// zero, so every burst starts from phase zero.
// The configuration port writes one register per cycle with cfg_we high and is
// to be used only while no sample is in flight.
// One shared 35x18 signed multiplier forms the envelope, the amplitude and
// carrier products and the gain product in turn, behind two reads of the
// quarter-wave sine ROM. A taken beat passes the MOD, CAR, ENV, CARM, GAIN and
// OUT steps to the output register, and no new beat is taken before it is idle.
// The finished sample sits in an output register. When the receiver stalls, the
// next sample is computed and waits in the last step until the register frees,
// and no further input beat is taken meanwhile.
// Reset is synchronous: the registers return to their reset values, both phases
// and the index clear, and the output register is emptied.
module am_wave_generator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  amwg_in_if.sink                         in_ch,
  amwg_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [amwg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [amwg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PB  = amwg_pkg::PHASE_BITS;
  localparam int QB  = amwg_pkg::QTR_BITS;
  localparam int TB  = amwg_pkg::TURN_BITS;
  localparam int AW  = amwg_pkg::ROM_AW;
  localparam int SW  = amwg_pkg::SINE_W;
  localparam int IW  = amwg_pkg::INDEX_W;
  localparam int OW  = amwg_pkg::SAMPLE_W;
  localparam int MAW = 35;
  localparam int MBW = 18;
  localparam int PW  = MAW + MBW;
  localparam int EW  = 18;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MOD  = 7'b0000010,
    ST_CAR  = 7'b0000100,
    ST_ENV  = 7'b0001000,
    ST_CARM = 7'b0010000,
    ST_GAIN = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic [31:0] carrier_step_r;
  logic [31:0] mod_step_r;
  logic [15:0] amplitude_r;
  logic [15:0] mod_depth_r;
  logic [15:0] norm_gain_r;
  logic [15:0] burst_length_r;

  logic [PB-1:0] car_phase_r;
  logic [PB-1:0] mod_phase_r;
  logic [IW-1:0] idx_r;

  logic signed [PW-1:0] prod_r;

  logic                 out_valid_r;
  logic signed [OW-1:0] out_sample_r;
  logic [IW-1:0]        out_index_r;
  logic                 out_last_r;

  logic [TB-1:0]        rom_turn;
  logic [AW-1:0]        rom_addr;
  logic [SW-1:0]        rom_data;
  logic                 rom_neg;
  logic signed [15:0]   sine_w;

  logic signed [PW-1:0]  rnd15_w;
  logic signed [PW-1:0]  rnd30_w;
  logic signed [EW-1:0]  env_w;
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PW-1:0]  mul_p;
  logic signed [OW-1:0]  sat_w;

  logic [IW:0] blen_eff;
  logic        last_w;
  logic        in_fire;
  logic        out_load;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample       = out_sample_r;
  assign out_ch.sample_index = out_index_r;
  assign out_ch.last         = out_last_r;

  // Fold the top bits of the selected phase onto the quarter-wave table.
  assign rom_turn = (state_r == ST_MOD) ? mod_phase_r[PB-1 -: TB] : car_phase_r[PB-1 -: TB];
  assign rom_addr = rom_turn[QB] ? (AW'(amwg_pkg::SINE_ENTRIES) - {1'b0, rom_turn[QB-1:0]})
                                 : {1'b0, rom_turn[QB-1:0]};

  amwg_sine_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  assign rom_neg = (state_r == ST_CAR) ? mod_phase_r[PB-1] : car_phase_r[PB-1];
  assign sine_w  = rom_neg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

  assign rnd15_w = (prod_r + PW'(64'sd16384)) >>> 15;
  assign rnd30_w = (prod_r + PW'(64'sd536870912)) >>> 30;
  assign env_w   = rnd15_w[EW-1:0] + EW'(32768);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_CAR: begin
        mul_a = MAW'(sine_w);
        mul_b = $signed({2'b00, mod_depth_r});
      end
      ST_ENV: begin
        mul_a = MAW'(env_w);
        mul_b = $signed({2'b00, amplitude_r});
      end
      ST_CARM: begin
        mul_a = prod_r[MAW-1:0];
        mul_b = MBW'(sine_w);
      end
      ST_GAIN: begin
        mul_a = rnd15_w[MAW-1:0];
        mul_b = $signed({2'b00, norm_gain_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  always_comb begin
    if (rnd30_w > PW'(64'sd262143)) begin
      sat_w = OW'(262143);
    end else if (rnd30_w < PW'(-64'sd262144)) begin
      sat_w = OW'(-262144);
    end else begin
      sat_w = rnd30_w[OW-1:0];
    end
  end

  assign blen_eff = (burst_length_r == '0) ? (IW+1)'(1) : {1'b0, burst_length_r};
  assign last_w   = ({1'b0, idx_r} + (IW+1)'(1)) >= blen_eff;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_MOD;
      ST_MOD:  state_nxt = ST_CAR;
      ST_CAR:  state_nxt = ST_ENV;
      ST_ENV:  state_nxt = ST_CARM;
      ST_CARM: state_nxt = ST_GAIN;
      ST_GAIN: state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      carrier_step_r <= '0;
      mod_step_r     <= '0;
      amplitude_r    <= '0;
      mod_depth_r    <= '0;
      norm_gain_r    <= 16'd32768;
      burst_length_r <= 16'd1;
      car_phase_r    <= '0;
      mod_phase_r    <= '0;
      idx_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_idx)
          amwg_pkg::REG_CARRIER_STEP: carrier_step_r <= cfg_wdata;
          amwg_pkg::REG_MOD_STEP:     mod_step_r     <= cfg_wdata;
          amwg_pkg::REG_AMPLITUDE:    amplitude_r    <= cfg_wdata[15:0];
          amwg_pkg::REG_MOD_DEPTH:    mod_depth_r    <= cfg_wdata[15:0];
          amwg_pkg::REG_NORM_GAIN:    norm_gain_r    <= cfg_wdata[15:0];
          amwg_pkg::REG_BURST_LENGTH: burst_length_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      if (in_fire && in_ch.restart) begin
        car_phase_r <= '0;
        mod_phase_r <= '0;
        idx_r       <= '0;
      end else if (out_load) begin
        if (last_w) begin
          car_phase_r <= '0;
          mod_phase_r <= '0;
          idx_r       <= '0;
        end else begin
          car_phase_r <= car_phase_r + PB'(carrier_step_r);
          mod_phase_r <= mod_phase_r + PB'(mod_step_r);
          idx_r       <= idx_r + IW'(1);
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r != ST_OUT) begin
      prod_r <= mul_p;
    end
    if (out_load) begin
      out_sample_r <= sat_w;
      out_index_r  <= idx_r;
      out_last_r   <= last_w;
    end
  end

  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_MOD)
    else $error("accepted beat did not start the sequence");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && last_w |=> idx_r == '0 && car_phase_r == '0 && mod_phase_r == '0)
    else $error("end of burst did not clear index and phases");

  a_not_last_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && !last_w |=> ({1'b0, out_index_r} + (IW+1)'(1)) < blen_eff)
    else $error("non-final sample index reached burst length");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready && state_r == ST_OUT |=> state_r == ST_OUT)
    else $error("sequencer left its last step while the output was held");

endmodule
